// File: design/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg: shared types and calendar functions for the date adder
// Control word and status types for the sequencer, and the month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

  localparam int unsigned PC_W = 4;

  localparam logic [3:0]  JAN        = 4'd1;
  localparam logic [3:0]  FEB        = 4'd2;
  localparam logic [3:0]  MAR        = 4'd3;
  localparam logic [3:0]  DEC        = 4'd12;
  localparam logic [4:0]  DAYS_31    = 5'd31;
  localparam logic [8:0]  CYCLE_400  = 9'd400;
  localparam logic [13:0] CYCLE_400W = 14'd400;
  localparam logic [15:0] YEAR_SPAN  = 16'd365;
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MOD,
    OP_CLAMP,
    OP_YEAR,
    OP_LEFT,
    OP_YEND,
    OP_MONTH,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_YEAR,
    COND_MONTH,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic [2:0]      k;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ctl_t;

  typedef struct packed {
    logic no_input;
    logic year_more;
    logic month_more;
    logic out_busy;
  } stat_t;

  // r is the year modulo 400
  function automatic logic is_leap(input logic [8:0] r);
    logic lp;
    if (r == 9'd0) begin
      lp = 1'b1;
    end else if (r == 9'd100 || r == 9'd200 || r == 9'd300) begin
      lp = 1'b0;
    end else begin
      lp = (r[1:0] == 2'b00);
    end
    return lp;
  endfunction

  function automatic logic [8:0] r_inc(input logic [8:0] r);
    return (r == CYCLE_400 - 9'd1) ? 9'd0 : r + 9'd1;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    case (m)
      4'd2:    len = lp ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] db;
    case (m)
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage

`default_nettype wire

// File: design/dad_ucode.sv
// ----------------------------------------------------------------------------
// dad_ucode: program counter and control store
// Steps through the fixed program; a step repeats while its condition holds.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_ucode (
  input  wire            clk,
  input  wire            rst,
  input  dad_pkg::stat_t stat,
  output dad_pkg::ctl_t  ctl
);
  import dad_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            rep;

  function automatic ctl_t rom_word(input logic [PC_W-1:0] a);
    ctl_t w;
    case (a)
      4'd0:    w = '{OP_IDLE,   3'd0, COND_NO_INPUT, 4'd0,  1'b0};
      4'd1:    w = '{OP_MOD,    3'd5, COND_NONE,     4'd0,  1'b0};
      4'd2:    w = '{OP_MOD,    3'd4, COND_NONE,     4'd0,  1'b0};
      4'd3:    w = '{OP_MOD,    3'd3, COND_NONE,     4'd0,  1'b0};
      4'd4:    w = '{OP_MOD,    3'd2, COND_NONE,     4'd0,  1'b0};
      4'd5:    w = '{OP_MOD,    3'd1, COND_NONE,     4'd0,  1'b0};
      4'd6:    w = '{OP_MOD,    3'd0, COND_NONE,     4'd0,  1'b0};
      4'd7:    w = '{OP_CLAMP,  3'd0, COND_NONE,     4'd0,  1'b0};
      4'd8:    w = '{OP_YEAR,   3'd0, COND_YEAR,     4'd8,  1'b0};
      4'd9:    w = '{OP_LEFT,   3'd0, COND_NONE,     4'd0,  1'b0};
      4'd10:   w = '{OP_YEND,   3'd0, COND_NONE,     4'd0,  1'b0};
      4'd11:   w = '{OP_MONTH,  3'd0, COND_MONTH,    4'd11, 1'b0};
      4'd12:   w = '{OP_FINISH, 3'd0, COND_OUT_BUSY, 4'd12, 1'b1};
      default: w = '{OP_IDLE,   3'd0, COND_NO_INPUT, 4'd0,  1'b1};
    endcase
    return w;
  endfunction

  assign ctl = rom_word(pc);

  always_comb begin
    case (ctl.cond)
      COND_NO_INPUT: rep = stat.no_input;
      COND_YEAR:     rep = stat.year_more;
      COND_MONTH:    rep = stat.month_more;
      COND_OUT_BUSY: rep = stat.out_busy;
      default:       rep = 1'b0;
    endcase
    if (rep) begin
      pc_next = ctl.target;
    end else if (ctl.last) begin
      pc_next = '0;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// File: design/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath: date registers and step arithmetic
// Executes one control word per cycle and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_datapath (
  input  wire            clk,
  input  wire            rst,
  input  dad_pkg::ctl_t  ctl,
  input  wire            in_valid,
  input  wire  [13:0]    in_year,
  input  wire  [3:0]     in_month,
  input  wire  [4:0]     in_day,
  input  wire  [15:0]    in_offset,
  input  wire            out_ready,
  output dad_pkg::stat_t stat,
  output logic           out_valid,
  output logic [13:0]    out_year,
  output logic [3:0]     out_month,
  output logic [4:0]     out_day
);
  import dad_pkg::*;

  logic [13:0] y;
  logic [13:0] r;
  logic [3:0]  m;
  logic [4:0]  d;
  logic [15:0] n;
  logic [8:0]  left;

  logic        lp0;
  logic        lp1;
  logic [8:0]  r_up;
  logic [4:0]  mlen;
  logic [4:0]  gap;
  logic [13:0] modk;
  logic [8:0]  doy;

  assign lp0  = is_leap(r[8:0]);
  assign r_up = r_inc(r[8:0]);
  assign lp1  = is_leap(r_up);
  assign mlen = month_len(m, lp0);
  assign gap  = mlen - d;
  assign modk = CYCLE_400W << ctl.k;
  assign doy  = days_before(m) + {4'd0, d} + {8'd0, lp0 && (m > FEB)};

  assign stat.no_input   = !in_valid;
  assign stat.year_more  = (n >= YEAR_SPAN);
  assign stat.month_more = (m < DEC) && ({11'd0, gap} < n);
  assign stat.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_IDLE: begin
        if (in_valid) begin
          y <= in_year;
          r <= in_year;
          n <= in_offset;
          if (in_month == 4'd0) begin
            m <= JAN;
          end else if (in_month > DEC) begin
            m <= DEC;
          end else begin
            m <= in_month;
          end
          d <= (in_day == 5'd0) ? 5'd1 : in_day;
        end
      end
      OP_MOD: begin
        if (r >= modk) begin
          r <= r - modk;
        end
      end
      OP_CLAMP: begin
        if (d > mlen) begin
          d <= mlen;
        end
      end
      OP_YEAR: begin
        if (stat.year_more) begin
          n <= n - YEAR_SPAN;
          if (lp0 && (m < MAR)) begin
            if (d > 5'd1) begin
              y <= y + 14'd1;
              r <= {5'd0, r_up};
              d <= d - 5'd1;
            end else if (m == JAN) begin
              m <= DEC;
              d <= DAYS_31;
            end else begin
              y <= y + 14'd1;
              r <= {5'd0, r_up};
              m <= JAN;
              d <= DAYS_31;
            end
          end else if (!lp0 && lp1 && (m >= MAR)) begin
            y <= y + 14'd1;
            r <= {5'd0, r_up};
            if (d > 5'd1) begin
              d <= d - 5'd1;
            end else begin
              m <= m - 4'd1;
              d <= month_len(m - 4'd1, lp1);
            end
          end else begin
            y <= y + 14'd1;
            r <= {5'd0, r_up};
          end
        end
      end
      OP_LEFT: begin
        left <= YEAR_DAYS + {8'd0, lp0} - doy;
      end
      OP_YEND: begin
        if ({7'd0, left} < n) begin
          n <= n - {7'd0, left} - 16'd1;
          y <= y + 14'd1;
          r <= {5'd0, r_up};
          m <= JAN;
          d <= 5'd1;
        end
      end
      OP_MONTH: begin
        if (stat.month_more) begin
          n <= n - {11'd0, gap} - 16'd1;
          m <= m + 4'd1;
          d <= 5'd1;
        end
      end
      OP_FINISH: begin
        if (!stat.out_busy) begin
          out_year  <= y;
          out_month <= m;
          out_day   <= d + n[4:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == OP_FINISH && !stat.out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: design/date_add_days.sv
// ----------------------------------------------------------------------------
// date_add_days: Gregorian date plus a day offset
// Adds a non-negative number of days to a start date.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item is a start date and a day offset. Output
// stream (m_*): one item, the resulting date, per input item.
// The block works on one item at a time. s_tready is high only while the
// sequencer waits at its first step. After acceptance it reduces the year
// modulo 400 and limits the day to the month, repeats its year step for
// each whole 365-day span (offset / 365, at most 179) and leaves that loop,
// works out the days left in the year and crosses the year end, repeats
// its month step for each month crossed (at most 11) and leaves that loop,
// and then loads the result register. Acceptance returns in the cycle after
// the result register loads.
// The result register holds while m_tready is low, and the next item may
// be accepted and worked on meanwhile; it then waits at its last step.
// Reset (rst, synchronous) returns the sequencer to its first step and
// empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module date_add_days (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], day_offset[38:23]
  input  wire  [39:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // end_year[13:0], end_month[17:14], end_day[22:18]
  output logic [23:0] m_tdata
);
  import dad_pkg::*;

  ctl_t        ctl;
  stat_t       stat;
  logic [13:0] end_year;
  logic [3:0]  end_month;
  logic [4:0]  end_day;

  dad_ucode u_ucode (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  dad_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (s_tvalid),
    .in_year   (s_tdata[13:0]),
    .in_month  (s_tdata[17:14]),
    .in_day    (s_tdata[22:18]),
    .in_offset (s_tdata[38:23]),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_year  (end_year),
    .out_month (end_month),
    .out_day   (end_day)
  );

  assign s_tready = (ctl.op == OP_IDLE);
  assign m_tdata  = {1'b0, end_day, end_month, end_year};

endmodule

`default_nettype wire

// File: design/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker: port-level checks for the date adder
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while one is in work");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:14] != 4'd0 && m_tdata[17:14] <= 4'd12)
    else $error("result month out of range");

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/date_add_days_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_test: self-checking bench for the Gregorian date adder
// Drives start dates with day offsets into the slave stream and checks every
// end date on the master stream against a calendar predictor. Both sides idle
// at random, and the receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
} cal_date_t;

class date_sum_board;
  cal_date_t dates_due[$];
  int        mismatches;
  int        checked;

  function new();
    mismatches = 0;
    checked    = 0;
  endfunction

  function automatic bit leap_year(int unsigned y);
    if (y % 100 != 0) return (y % 4) == 0;
    return (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic void step_back(inout int unsigned y, inout int unsigned m,
                                    inout int unsigned d);
    if (d > 1) begin
      d = d - 1;
    end else if (m == 1) begin
      y = y - 1;
      m = 12;
      d = 31;
    end else begin
      m = m - 1;
      d = days_in(y, m);
    end
  endfunction

  // end date of start date plus offset, start fields clamped to a valid date
  function automatic cal_date_t add_days_to_date(logic [13:0] sy, logic [3:0] sm,
                                                 logic [4:0] sd, logic [15:0] offset);
    int unsigned y, m, d, n, left, k;
    cal_date_t   res;
    y = 32'(sy);
    m = 32'(sm);
    d = 32'(sd);
    n = 32'(offset);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > days_in(y, m)) d = days_in(y, m);
    while (n >= 365) begin
      n = n - 365;
      if (leap_year(y)) begin
        y = y + 1;
        if (m < 3) step_back(y, m, d);
      end else if (leap_year(y + 1)) begin
        y = y + 1;
        if (m >= 3) step_back(y, m, d);
      end else begin
        y = y + 1;
      end
    end
    left = days_in(y, m) - d;
    for (k = m + 1; k <= 12; k++) left = left + days_in(y, k);
    if (n > left) begin
      n = n - (left + 1);
      y = y + 1;
      m = 1;
      d = 1;
    end
    while (m < 12 && n > days_in(y, m) - d) begin
      n = n - (days_in(y, m) - d + 1);
      m = m + 1;
      d = 1;
    end
    d = d + n;
    res.year  = y[13:0];
    res.month = m[3:0];
    res.day   = d[4:0];
    return res;
  endfunction

  function void note_start(logic [39:0] item);
    dates_due.push_back(add_days_to_date(item[13:0], item[17:14], item[22:18],
                                         item[38:23]));
  endfunction

  function void check_end(logic [23:0] item);
    cal_date_t want;
    checked++;
    if (dates_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected end date %0d-%0d-%0d", item[13:0], item[17:14], item[22:18]);
      return;
    end
    want = dates_due.pop_front();
    if (item[13:0] !== want.year || item[17:14] !== want.month ||
        item[22:18] !== want.day) begin
      mismatches++;
      if (mismatches <= 10)
        $display("end date mismatch: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                 want.year, want.month, want.day,
                 item[13:0], item[17:14], item[22:18]);
    end
  endfunction
endclass

module date_add_days_test;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 600;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  date_sum_board board = new();
  int            quiet_cycles = 0;
  bit            sender_calm = 0;
  bit            receiver_calm = 0;

  date_add_days dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_start(s_tdata);
      if (m_tvalid && m_tready) board.check_end(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("date_add_days_test NOT OK");
    $finish;
  end

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) receiver_calm = ~receiver_calm;
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (!hold_done && board.checked >= 100) begin
        hold_done = 1;
        hold_left = LONG_HOLD - 1;
        m_tready  = 1'b0;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (!receiver_calm) stall_left = idle_cycles();
      end
    end
  end

  task automatic send_start(input logic [13:0] y, input logic [3:0] m,
                            input logic [4:0] d, input logic [15:0] n);
    int gap;
    s_tdata  = {1'b0, n, d, m, y};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if ($urandom_range(0, 99) == 0) sender_calm = ~sender_calm;
    gap = sender_calm ? 0 : idle_cycles();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (board.dates_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_start();
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [15:0] n;
    int          pick;
    int          len;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      y = 14'($urandom_range(0, 16383));
    end else if (pick < 4) begin
      y = 14'($urandom_range(0, 99) * 100 + $urandom_range(0, 2));
    end else begin
      y = 14'($urandom_range(1, 9999));
    end
    m = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12));
    len = board.days_in(32'(y), (m < 4'd1) ? 32'd1 : (m > 4'd12) ? 32'd12 : 32'(m));
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      d = 5'($urandom_range(0, 31));
    end else if (pick < 7) begin
      d = 5'(len);
    end else begin
      d = 5'($urandom_range(1, len));
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      n = 16'($urandom_range(0, 62));
    end else if (pick < 4) begin
      n = 16'($urandom_range(0, 400));
    end else if (pick < 6) begin
      n = 16'($urandom_range(1, 179) * 365 + $urandom_range(0, 4) - 2);
    end else begin
      n = 16'($urandom_range(0, 65535));
    end
    send_start(y, m, d, n);
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_start(14'd2000,  4'd2,  5'd29, 16'd0);
    send_start(14'd0,     4'd1,  5'd1,  16'd0);
    send_start(14'd16383, 4'd15, 5'd31, 16'd65535);
    send_start(14'd2023,  4'd0,  5'd0,  16'd1);
    send_start(14'd2023,  4'd13, 5'd5,  16'd10);
    send_start(14'd2023,  4'd2,  5'd31, 16'd1);
    send_start(14'd2024,  4'd2,  5'd30, 16'd1);
    send_start(14'd1900,  4'd2,  5'd29, 16'd1);
    send_start(14'd2000,  4'd2,  5'd29, 16'd365);
    send_start(14'd1999,  4'd3,  5'd1,  16'd365);
    send_start(14'd2023,  4'd12, 5'd31, 16'd1);
    send_start(14'd2023,  4'd12, 5'd31, 16'd0);
    send_start(14'd2024,  4'd1,  5'd1,  16'd366);
    send_start(14'd2024,  4'd1,  5'd1,  16'd365);
    send_start(14'd9999,  4'd12, 5'd31, 16'd1);
    send_start(14'd1,     4'd1,  5'd1,  16'd65535);
    send_start(14'd2100,  4'd2,  5'd28, 16'd1);
    send_start(14'd2400,  4'd2,  5'd28, 16'd1);
    send_start(14'd2023,  4'd1,  5'd31, 16'd29);
    send_start(14'd0,     4'd3,  5'd1,  16'd365);
    send_start(14'd2023,  4'd4,  5'd30, 16'd364);
    send_start(14'd2023,  4'd6,  5'd15, 16'd730);
    send_start(14'd16383, 4'd12, 5'd31, 16'd1);
    drain_results();

    repeat (750) send_random_start();
    drain_results();
    repeat (750) send_random_start();
    drain_results();
    repeat (250) @(posedge clk);

    if (board.mismatches == 0 && board.dates_due.size() == 0) begin
      $display("date_add_days_test OK");
    end else begin
      $display("date_add_days_test NOT OK");
    end
    $finish;
  end
endmodule
